// ===== hdl/slx_pkg.sv =====
// Shared types, constants and helpers for the source lexer.
package slx_pkg;

   localparam int OFFSET_BITS   = 24;
   localparam int ROW_BITS      = 20;
   localparam int COL_BITS      = 16;
   localparam int KEYWORD_CHARS = 8;

   localparam int KIND_W = 6;
   localparam int ERR_W  = 3;
   localparam int OFF_W  = 24;
   localparam int LEN_W  = 24;
   localparam int ROWF_W = 20;
   localparam int COLF_W = 16;
   localparam int NLEN_W = $clog2(KEYWORD_CHARS + 2);

   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   localparam logic [KIND_W-1:0] K_INT      = 6'd0;
   localparam logic [KIND_W-1:0] K_FLOAT    = 6'd1;
   localparam logic [KIND_W-1:0] K_STRING   = 6'd2;
   localparam logic [KIND_W-1:0] K_CHAR     = 6'd3;
   localparam logic [KIND_W-1:0] K_NAME     = 6'd4;
   localparam logic [KIND_W-1:0] K_PLUS     = 6'd5;
   localparam logic [KIND_W-1:0] K_MINUS    = 6'd6;
   localparam logic [KIND_W-1:0] K_STAR     = 6'd7;
   localparam logic [KIND_W-1:0] K_SLASH    = 6'd8;
   localparam logic [KIND_W-1:0] K_BANG     = 6'd9;
   localparam logic [KIND_W-1:0] K_TILDE    = 6'd10;
   localparam logic [KIND_W-1:0] K_PERCENT  = 6'd11;
   localparam logic [KIND_W-1:0] K_SHL      = 6'd12;
   localparam logic [KIND_W-1:0] K_SHR      = 6'd13;
   localparam logic [KIND_W-1:0] K_LT       = 6'd14;
   localparam logic [KIND_W-1:0] K_LE       = 6'd15;
   localparam logic [KIND_W-1:0] K_GT       = 6'd16;
   localparam logic [KIND_W-1:0] K_GE       = 6'd17;
   localparam logic [KIND_W-1:0] K_EQEQ     = 6'd18;
   localparam logic [KIND_W-1:0] K_NE       = 6'd19;
   localparam logic [KIND_W-1:0] K_AMP      = 6'd20;
   localparam logic [KIND_W-1:0] K_CARET    = 6'd21;
   localparam logic [KIND_W-1:0] K_PIPE     = 6'd22;
   localparam logic [KIND_W-1:0] K_ANDAND   = 6'd23;
   localparam logic [KIND_W-1:0] K_OROR     = 6'd24;
   localparam logic [KIND_W-1:0] K_ASSIGN   = 6'd25;
   localparam logic [KIND_W-1:0] K_LPAREN   = 6'd26;
   localparam logic [KIND_W-1:0] K_RPAREN   = 6'd27;
   localparam logic [KIND_W-1:0] K_LBRACE   = 6'd28;
   localparam logic [KIND_W-1:0] K_RBRACE   = 6'd29;
   localparam logic [KIND_W-1:0] K_LBRACKET = 6'd30;
   localparam logic [KIND_W-1:0] K_RBRACKET = 6'd31;
   localparam logic [KIND_W-1:0] K_COMMA    = 6'd32;
   localparam logic [KIND_W-1:0] K_SEMI     = 6'd33;
   localparam logic [KIND_W-1:0] K_COLON    = 6'd34;
   localparam logic [KIND_W-1:0] K_DOT      = 6'd35;
   localparam logic [KIND_W-1:0] K_KEYWORD0 = 6'd36;
   localparam logic [KIND_W-1:0] K_EOF      = 6'd49;

   localparam logic [ERR_W-1:0] E_NONE     = 3'd0;
   localparam logic [ERR_W-1:0] E_UNEXP    = 3'd1;
   localparam logic [ERR_W-1:0] E_OPEN_STR = 3'd2;
   localparam logic [ERR_W-1:0] E_OPEN_CHR = 3'd3;
   localparam logic [ERR_W-1:0] E_NO_FRAC  = 3'd4;

   localparam int NUM_KEYWORDS = 13;

   // keyword text, first character in the low byte, zero padded
   localparam logic [8*KEYWORD_CHARS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
      64'h0000_0000_6575_7274,   // true
      64'h0000_0065_736c_6166,   // false
      64'h0000_0000_0072_6176,   // var
      64'h0000_0000_0000_6669,   // if
      64'h0000_0000_6573_6c65,   // else
      64'h0000_0065_6c69_6877,   // while
      64'h0000_006b_6165_7262,   // break
      64'h6575_6e69_746e_6f63,   // continue
      64'h0000_0000_0074_6e69,   // int
      64'h0000_0074_616f_6c66,   // float
      64'h0000_0000_6c6f_6f62,   // bool
      64'h0000_676e_6972_7473,   // string
      64'h0000_0000_7261_6863    // char
   };

   typedef struct packed {
      logic       func;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] token_kind;
      logic [ERR_W-1:0]  error_code;
      logic [OFF_W-1:0]  start_offset;
      logic [LEN_W-1:0]  token_length;
      logic [ROWF_W-1:0] start_row;
      logic [COLF_W-1:0] start_col;
      logic              run_last;
   } rsp_type;

   // results of one transaction, in order
   typedef struct packed {
      logic    r0_valid;
      rsp_type r0;
      logic    r1_valid;
      rsp_type r1;
   } result_pair_type;

   function automatic logic [LEN_W-1:0] len_sat(input logic [OFFSET_BITS-1:0] d);
      logic [OFFSET_BITS-1:0] hi;
      hi = d >> LEN_W;
      if (OFFSET_BITS > LEN_W && hi != '0) return LEN_MAX;
      return LEN_W'(d);
   endfunction

   function automatic rsp_type make_rsp(input logic [KIND_W-1:0] kind,
                                        input logic [ERR_W-1:0] err,
                                        input logic [OFFSET_BITS-1:0] off,
                                        input logic [LEN_W-1:0] len,
                                        input logic [ROW_BITS-1:0] row,
                                        input logic [COL_BITS-1:0] col);
      rsp_type r;
      r.token_kind   = kind;
      r.error_code   = err;
      r.start_offset = OFF_W'(off);
      r.token_length = len;
      r.start_row    = ROWF_W'(row);
      r.start_col    = COLF_W'(col);
      r.run_last     = 1'b0;
      return r;
   endfunction

endpackage

// ===== hdl/slx_step.sv =====
// Lexer state registers and the next-state and result logic for one byte.
module slx_step (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  slx_pkg::req_type        req,
   output slx_pkg::result_pair_type res
);

   typedef enum logic [11:0] {
      M_IDLE    = 12'b0000_0000_0001,
      M_BANG    = 12'b0000_0000_0010,
      M_LESS    = 12'b0000_0000_0100,
      M_GREATER = 12'b0000_0000_1000,
      M_EQUAL   = 12'b0000_0001_0000,
      M_AND     = 12'b0000_0010_0000,
      M_PIPE    = 12'b0000_0100_0000,
      M_INT     = 12'b0000_1000_0000,
      M_FRAC    = 12'b0001_0000_0000,
      M_NAME    = 12'b0010_0000_0000,
      M_STR     = 12'b0100_0000_0000,
      M_CHR     = 12'b1000_0000_0000
   } mode_type;

   typedef struct packed {
      mode_type                              mode;
      logic [slx_pkg::OFFSET_BITS-1:0]       ts_off;
      logic [slx_pkg::ROW_BITS-1:0]          ts_row;
      logic [slx_pkg::COL_BITS-1:0]          ts_col;
      logic [slx_pkg::OFFSET_BITS-1:0]       cur_off;
      logic [slx_pkg::ROW_BITS-1:0]          cur_row;
      logic [slx_pkg::COL_BITS-1:0]          cur_col;
      logic [8*slx_pkg::KEYWORD_CHARS-1:0]   nbuf;
      logic [slx_pkg::NLEN_W-1:0]            nlen;
      logic                                  bslash;
      logic                                  frac_seen;
      logic                                  discard;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode: M_IDLE, ts_off: '0, ts_row: slx_pkg::ROW_BITS'(1),
      ts_col: slx_pkg::COL_BITS'(1), cur_off: '0, cur_row: slx_pkg::ROW_BITS'(1),
      cur_col: slx_pkg::COL_BITS'(1), nbuf: '0, nlen: '0, bslash: 1'b0,
      frac_seen: 1'b0, discard: 1'b0};

   state_type state_ff, state_in;

   logic [7:0]                      c;
   logic                            is_digit, is_name_start;
   logic [slx_pkg::OFFSET_BITS-1:0] off_inc;
   logic [slx_pkg::KIND_W-1:0]      name_kind;
   slx_pkg::rsp_type                pend_r, thru_r, err_r;

   // idle decode of the byte
   logic                            id_single, id_start, id_eof, id_err;
   logic [slx_pkg::KIND_W-1:0]      id_kind;
   mode_type                        id_mode;

   assign c             = req.char_code;
   assign is_digit      = (c >= 8'h30) && (c <= 8'h39);
   assign is_name_start = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
                          || (c == 8'h5f);
   assign off_inc       = (state_ff.cur_off == '1) ? state_ff.cur_off
                                                   : state_ff.cur_off + 1'b1;

   // keyword match: unused buffer bytes are always zero
   always_comb begin
      name_kind = slx_pkg::K_NAME;
      if (state_ff.nlen <= slx_pkg::NLEN_W'(slx_pkg::KEYWORD_CHARS)) begin
         for (int i = 0; i < slx_pkg::NUM_KEYWORDS; i++) begin
            if (state_ff.nbuf == slx_pkg::KW_TEXT[i])
               name_kind = slx_pkg::K_KEYWORD0 + slx_pkg::KIND_W'(i);
         end
      end
   end

   always_comb begin
      id_single = 1'b0;
      id_start  = 1'b0;
      id_eof    = 1'b0;
      id_err    = 1'b0;
      id_kind   = slx_pkg::K_INT;
      id_mode   = M_IDLE;
      case (c) inside
         8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32: ;
         8'h2b: begin id_single = 1'b1; id_kind = slx_pkg::K_PLUS;     end
         8'h2d: begin id_single = 1'b1; id_kind = slx_pkg::K_MINUS;    end
         8'h2a: begin id_single = 1'b1; id_kind = slx_pkg::K_STAR;     end
         8'h2f: begin id_single = 1'b1; id_kind = slx_pkg::K_SLASH;    end
         8'h7e: begin id_single = 1'b1; id_kind = slx_pkg::K_TILDE;    end
         8'h25: begin id_single = 1'b1; id_kind = slx_pkg::K_PERCENT;  end
         8'h5e: begin id_single = 1'b1; id_kind = slx_pkg::K_CARET;    end
         8'h28: begin id_single = 1'b1; id_kind = slx_pkg::K_LPAREN;   end
         8'h29: begin id_single = 1'b1; id_kind = slx_pkg::K_RPAREN;   end
         8'h7b: begin id_single = 1'b1; id_kind = slx_pkg::K_LBRACE;   end
         8'h7d: begin id_single = 1'b1; id_kind = slx_pkg::K_RBRACE;   end
         8'h5b: begin id_single = 1'b1; id_kind = slx_pkg::K_LBRACKET; end
         8'h5d: begin id_single = 1'b1; id_kind = slx_pkg::K_RBRACKET; end
         8'h2c: begin id_single = 1'b1; id_kind = slx_pkg::K_COMMA;    end
         8'h3b: begin id_single = 1'b1; id_kind = slx_pkg::K_SEMI;     end
         8'h3a: begin id_single = 1'b1; id_kind = slx_pkg::K_COLON;    end
         8'h2e: begin id_single = 1'b1; id_kind = slx_pkg::K_DOT;      end
         8'h21: begin id_start = 1'b1; id_mode = M_BANG;    end
         8'h3c: begin id_start = 1'b1; id_mode = M_LESS;    end
         8'h3e: begin id_start = 1'b1; id_mode = M_GREATER; end
         8'h3d: begin id_start = 1'b1; id_mode = M_EQUAL;   end
         8'h26: begin id_start = 1'b1; id_mode = M_AND;     end
         8'h7c: begin id_start = 1'b1; id_mode = M_PIPE;    end
         8'h22: begin id_start = 1'b1; id_mode = M_STR;     end
         8'h27: begin id_start = 1'b1; id_mode = M_CHR;     end
         8'h00: id_eof = 1'b1;
         default: begin
            if (is_digit) begin
               id_start = 1'b1;
               id_mode  = M_INT;
            end else if (is_name_start) begin
               id_start = 1'b1;
               id_mode  = M_NAME;
            end else begin
               id_err = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      logic                       do_idle;
      logic                       p_valid, p_err;
      logic [slx_pkg::KIND_W-1:0] p_kind;
      slx_pkg::rsp_type           ir, eof_r;

      state_in = state_ff;
      res      = '0;
      do_idle  = 1'b0;
      p_valid  = 1'b0;
      p_err    = 1'b0;
      p_kind   = slx_pkg::K_INT;

      pend_r = slx_pkg::make_rsp(slx_pkg::K_INT, slx_pkg::E_NONE, state_ff.ts_off,
                                 slx_pkg::len_sat(state_ff.cur_off - state_ff.ts_off),
                                 state_ff.ts_row, state_ff.ts_col);
      thru_r = slx_pkg::make_rsp(slx_pkg::K_INT, slx_pkg::E_NONE, state_ff.ts_off,
                                 slx_pkg::len_sat(off_inc - state_ff.ts_off),
                                 state_ff.ts_row, state_ff.ts_col);
      err_r  = slx_pkg::make_rsp(slx_pkg::K_INT, slx_pkg::E_NONE, state_ff.ts_off, '0,
                                 state_ff.ts_row, state_ff.ts_col);
      eof_r  = slx_pkg::make_rsp(slx_pkg::K_EOF, slx_pkg::E_NONE, state_ff.cur_off, '0,
                                 state_ff.cur_row, state_ff.cur_col);
      ir     = eof_r;

      if (accept) begin
         if (state_ff.discard) begin
            if (req.func) state_in = STATE_RESET;
         end else if (req.func) begin
            // end of source: close the pending token, then end of file; an unfinished token gives only an error result
            unique case (state_ff.mode)
               M_BANG:    begin p_valid = 1'b1; p_kind = slx_pkg::K_BANG;   end
               M_LESS:    begin p_valid = 1'b1; p_kind = slx_pkg::K_LT;     end
               M_GREATER: begin p_valid = 1'b1; p_kind = slx_pkg::K_GT;     end
               M_EQUAL:   begin p_valid = 1'b1; p_kind = slx_pkg::K_ASSIGN; end
               M_AND:     begin p_valid = 1'b1; p_kind = slx_pkg::K_AMP;    end
               M_PIPE:    begin p_valid = 1'b1; p_kind = slx_pkg::K_PIPE;   end
               M_INT:     begin p_valid = 1'b1; p_kind = slx_pkg::K_INT;    end
               M_FRAC: begin
                  if (state_ff.frac_seen) begin
                     p_valid = 1'b1;
                     p_kind  = slx_pkg::K_FLOAT;
                  end else begin
                     p_err            = 1'b1;
                     err_r.error_code = slx_pkg::E_NO_FRAC;
                  end
               end
               M_NAME: begin p_valid = 1'b1; p_kind = name_kind; end
               M_STR: begin
                  p_err            = 1'b1;
                  err_r.error_code = slx_pkg::E_OPEN_STR;
               end
               M_CHR: begin
                  p_err            = 1'b1;
                  err_r.error_code = slx_pkg::E_OPEN_CHR;
               end
               default: ;
            endcase
            pend_r.token_kind = p_kind;
            if (p_err) begin
               res.r0_valid = 1'b1;
               res.r0       = err_r;
            end else if (p_valid) begin
               res.r0_valid = 1'b1;
               res.r0       = pend_r;
               res.r1_valid = 1'b1;
               res.r1       = eof_r;
            end else begin
               res.r0_valid = 1'b1;
               res.r0       = eof_r;
            end
            state_in = STATE_RESET;
         end else begin
            unique case (state_ff.mode)
               M_BANG, M_LESS, M_GREATER, M_EQUAL, M_AND, M_PIPE: begin
                  logic                       hit;
                  logic [slx_pkg::KIND_W-1:0] hk, k0;
                  hit = 1'b0;
                  hk  = slx_pkg::K_NE;
                  k0  = slx_pkg::K_BANG;
                  unique case (state_ff.mode)
                     M_BANG: begin
                        hit = (c == 8'h3d); hk = slx_pkg::K_NE; k0 = slx_pkg::K_BANG;
                     end
                     M_LESS: begin
                        hit = (c == 8'h3c) || (c == 8'h3d);
                        hk  = (c == 8'h3c) ? slx_pkg::K_SHL : slx_pkg::K_LE;
                        k0  = slx_pkg::K_LT;
                     end
                     M_GREATER: begin
                        hit = (c == 8'h3e) || (c == 8'h3d);
                        hk  = (c == 8'h3e) ? slx_pkg::K_SHR : slx_pkg::K_GE;
                        k0  = slx_pkg::K_GT;
                     end
                     M_EQUAL: begin
                        hit = (c == 8'h3d); hk = slx_pkg::K_EQEQ; k0 = slx_pkg::K_ASSIGN;
                     end
                     M_AND: begin
                        hit = (c == 8'h26); hk = slx_pkg::K_ANDAND; k0 = slx_pkg::K_AMP;
                     end
                     default: begin
                        hit = (c == 8'h7c); hk = slx_pkg::K_OROR; k0 = slx_pkg::K_PIPE;
                     end
                  endcase
                  state_in.mode = M_IDLE;
                  res.r0_valid  = 1'b1;
                  if (hit) begin
                     res.r0            = thru_r;
                     res.r0.token_kind = hk;
                  end else begin
                     res.r0            = pend_r;
                     res.r0.token_kind = k0;
                     do_idle           = 1'b1;
                  end
               end
               M_INT: begin
                  if (c == 8'h2e) begin
                     state_in.mode      = M_FRAC;
                     state_in.frac_seen = 1'b0;
                  end else if (!is_digit) begin
                     state_in.mode = M_IDLE;
                     res.r0_valid  = 1'b1;
                     res.r0        = pend_r;
                     do_idle       = 1'b1;
                  end
               end
               M_FRAC: begin
                  if (is_digit) begin
                     state_in.frac_seen = 1'b1;
                  end else if (!state_ff.frac_seen) begin
                     state_in.mode     = M_IDLE;
                     state_in.discard  = 1'b1;
                     res.r0_valid      = 1'b1;
                     res.r0            = err_r;
                     res.r0.error_code = slx_pkg::E_NO_FRAC;
                  end else begin
                     state_in.mode     = M_IDLE;
                     res.r0_valid      = 1'b1;
                     res.r0            = pend_r;
                     res.r0.token_kind = slx_pkg::K_FLOAT;
                     do_idle           = 1'b1;
                  end
               end
               M_NAME: begin
                  if (is_name_start || is_digit) begin
                     if (state_ff.nlen < slx_pkg::NLEN_W'(slx_pkg::KEYWORD_CHARS))
                        state_in.nbuf[8*state_ff.nlen[$clog2(slx_pkg::KEYWORD_CHARS)-1:0] +: 8]
                           = c;
                     if (state_ff.nlen <= slx_pkg::NLEN_W'(slx_pkg::KEYWORD_CHARS))
                        state_in.nlen = state_ff.nlen + 1'b1;
                  end else begin
                     state_in.mode     = M_IDLE;
                     res.r0_valid      = 1'b1;
                     res.r0            = pend_r;
                     res.r0.token_kind = name_kind;
                     do_idle           = 1'b1;
                  end
               end
               M_STR, M_CHR: begin
                  logic is_str;
                  is_str = (state_ff.mode == M_STR);
                  if (c == (is_str ? 8'h22 : 8'h27) && !state_ff.bslash) begin
                     state_in.mode     = M_IDLE;
                     res.r0_valid      = 1'b1;
                     res.r0            = thru_r;
                     res.r0.token_kind = is_str ? slx_pkg::K_STRING : slx_pkg::K_CHAR;
                  end else if (c == 8'h00 || c == 8'h0a) begin
                     state_in.mode     = M_IDLE;
                     state_in.discard  = 1'b1;
                     res.r0_valid      = 1'b1;
                     res.r0            = err_r;
                     res.r0.error_code = is_str ? slx_pkg::E_OPEN_STR : slx_pkg::E_OPEN_CHR;
                  end else begin
                     state_in.bslash = (c == 8'h5c);
                  end
               end
               default: begin
                  state_in.mode = M_IDLE;
                  do_idle       = 1'b1;
               end
            endcase

            if (do_idle) begin
               ir = slx_pkg::make_rsp(id_kind, slx_pkg::E_NONE, state_ff.cur_off,
                                      slx_pkg::LEN_W'(1), state_ff.cur_row, state_ff.cur_col);
               if (id_eof) begin
                  ir               = eof_r;
                  state_in.discard = 1'b1;
               end else if (id_err) begin
                  ir.error_code    = slx_pkg::E_UNEXP;
                  ir.token_length  = '0;
                  state_in.discard = 1'b1;
               end
               if (id_single || id_eof || id_err) begin
                  if (res.r0_valid) begin
                     res.r1_valid = 1'b1;
                     res.r1       = ir;
                  end else begin
                     res.r0_valid = 1'b1;
                     res.r0       = ir;
                  end
               end
               if (id_start) begin
                  state_in.mode   = id_mode;
                  state_in.ts_off = state_ff.cur_off;
                  state_in.ts_row = state_ff.cur_row;
                  state_in.ts_col = state_ff.cur_col;
                  state_in.bslash = 1'b0;
                  if (id_mode == M_NAME) begin
                     state_in.nbuf      = '0;
                     state_in.nbuf[7:0] = c;
                     state_in.nlen      = slx_pkg::NLEN_W'(1);
                  end
               end
            end

            // advance the position
            state_in.cur_off = off_inc;
            if (c == 8'h0a) begin
               state_in.cur_row = (state_ff.cur_row == '1) ? state_ff.cur_row
                                                          : state_ff.cur_row + 1'b1;
               state_in.cur_col = slx_pkg::COL_BITS'(1);
            end else begin
               state_in.cur_col = (state_ff.cur_col == '1) ? state_ff.cur_col
                                                          : state_ff.cur_col + 1'b1;
            end
         end

         if (res.r1_valid) res.r1.run_last = 1'b1;
         else if (res.r0_valid) res.r0.run_last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= STATE_RESET;
      else state_ff <= state_in;
   end

endmodule

// ===== hdl/slx_queue.sv =====
// Four-entry result queue taking up to two results per cycle.
module slx_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  slx_pkg::result_pair_type push,
   output logic                     room,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output slx_pkg::rsp_type         rsp_data
);

   slx_pkg::rsp_type slot_ff [4];
   logic [1:0]       wr_ff, rd_ff, wr_in, rd_in;
   logic [2:0]       count_ff, count_in;
   logic             pop;
   logic [1:0]       n_push;

   assign room      = (count_ff <= 3'd2);
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = slot_ff[rd_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign n_push    = 2'(push.r0_valid) + 2'(push.r1_valid);

   always_comb begin
      wr_in    = wr_ff + n_push;
      rd_in    = rd_ff + 2'(pop);
      count_in = count_ff + 3'(n_push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.r0_valid) slot_ff[wr_ff] <= push.r0;
      if (push.r1_valid) slot_ff[wr_ff + 2'd1] <= push.r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/source_lexer_top.sv =====
// Top level of the source lexer: byte stream in, token stream out.
//
//   channel | direction | payload            | transaction
//   req     | in        | slx_pkg::req_type  | one source byte or end marker
//   rsp     | out       | slx_pkg::rsp_type  | one token or error result
//
// One byte is taken per cycle; the lexer state update is a single pass of
// logic into the state registers. Each byte yields zero, one or two
// results, written into a four-entry queue that drains one per cycle while the consumer is ready, so
// a byte is held back only while fewer than two queue entries are free.
// Reset is synchronous and returns the lexer to row 1, column 1, offset 0.
module source_lexer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  slx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output slx_pkg::rsp_type rsp_data
);

   slx_pkg::result_pair_type results;
   logic                     accept;
   logic                     room;

   // take a transaction only when both of its results are sure to fit
   assign req_ready = room;
   assign accept    = req_valid && req_ready;

   slx_step u_step (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .res    (results)
   );

   // hold results until the consumer takes them
   slx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (results),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
